// File: hw/rtl/brf_pkg.sv
// Shared constants, codes and request type for the byte ring FIFO.
package brf_pkg;

  localparam int CAPACITY  = 256;  // power of two, at least 16
  localparam int MAX_BYTES = 8;    // at most BANKS
  localparam int BANKS     = 8;
  localparam int PW        = $clog2(CAPACITY);
  localparam int CW        = PW + 1;
  localparam int BW        = $clog2(BANKS);
  localparam int ROWS      = CAPACITY / BANKS;
  localparam int RW        = PW - BW;
  localparam int CNTW      = 4;
  localparam int DW        = 64;
  localparam int FUNCW     = 2;
  localparam int STW       = 2;
  localparam int IN_TDW    = 72;
  localparam int OUT_TDW   = 72;
  localparam int QDEPTH    = 2;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  typedef enum logic [FUNCW-1:0] {
    FN_PUT  = 2'd0,
    FN_GET  = 2'd1,
    FN_PEEK = 2'd2,
    FN_NOP  = 2'd3
  } func_e;

  typedef enum logic [STW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    func_e           func;
    logic [CNTW-1:0] cnt;
    logic [DW-1:0]   data;
  } req_t;

endpackage

// File: hw/rtl/byte_ring_fifo_multi_byte.sv
// Top level of the multi-byte ring FIFO: request front end and execution back end.
//
//  channel | tdata (low bit up)                         | tuser
//  s_axis  | put_data[63:0], byte_count[67:64], pad 0   | func[1:0]
//  m_axis  | moved_count[3:0], read_data[67:4], pad 0   | status[1:0]
//
// One request per cycle sustained while the result is taken. A result passes the queue entry,
// the registered read of the byte banks and the result register, in that order.
// Reset clears both ring counters, the queue and all valids; store contents stay
// undefined. A stalled result holds the back end; the queue takes two more requests,
// then the input stalls.
module byte_ring_fifo_multi_byte (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [brf_pkg::IN_TDW-1:0]     s_axis_tdata,  // put_data, byte_count
  input  logic [brf_pkg::FUNCW-1:0]      s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [brf_pkg::OUT_TDW-1:0]    m_axis_tdata,  // moved_count, read_data
  output logic [brf_pkg::STW-1:0]        m_axis_tuser   // status
);

  logic          req_valid, req_ready;
  brf_pkg::req_t req;

  brf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .req_valid_o   (req_valid),
    .req_o         (req),
    .req_ready_i   (req_ready)
  );

  brf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid),
    .req_i         (req),
    .req_ready_o   (req_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: hw/rtl/brf_front.sv
// Request front end: decode, count clamp and a two-entry request queue.
module brf_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [brf_pkg::IN_TDW-1:0]     s_axis_tdata,
  input  logic [brf_pkg::FUNCW-1:0]      s_axis_tuser,
  output logic                           req_valid_o,
  output brf_pkg::req_t                  req_o,
  input  logic                           req_ready_i
);

  brf_pkg::req_t                 entries_q [brf_pkg::QDEPTH];
  brf_pkg::req_t                 req_in;
  logic [brf_pkg::QAW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [brf_pkg::QCW-1:0]       cnt_q, cnt_d;
  logic [brf_pkg::CNTW-1:0]      raw_cnt;
  logic                          push, pop;

  assign raw_cnt = s_axis_tdata[brf_pkg::DW +: brf_pkg::CNTW];

  always_comb begin
    req_in.func = brf_pkg::func_e'(s_axis_tuser);
    req_in.data = s_axis_tdata[brf_pkg::DW-1:0];
    if (raw_cnt > brf_pkg::CNTW'(brf_pkg::MAX_BYTES)) begin
      req_in.cnt = brf_pkg::CNTW'(brf_pkg::MAX_BYTES);
    end else begin
      req_in.cnt = raw_cnt;
    end
  end

  assign s_axis_tready = (cnt_q != brf_pkg::QCW'(brf_pkg::QDEPTH));
  assign req_valid_o   = (cnt_q != '0);
  assign req_o         = entries_q[rptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = req_valid_o && req_ready_i;

  always_comb begin
    wptr_d = push ? wptr_q + brf_pkg::QAW'(1) : wptr_q;
    rptr_d = pop  ? rptr_q + brf_pkg::QAW'(1) : rptr_q;
    cnt_d  = cnt_q + brf_pkg::QCW'(push) - brf_pkg::QCW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= req_in;
    end
  end

endmodule

// File: hw/rtl/brf_back.sv
// Execution back end: ring counters, banked byte store and result register.
module brf_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  brf_pkg::req_t                  req_i,
  output logic                           req_ready_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [brf_pkg::OUT_TDW-1:0]    m_axis_tdata,
  output logic [brf_pkg::STW-1:0]        m_axis_tuser
);

  localparam int PADW = brf_pkg::OUT_TDW - brf_pkg::CNTW - brf_pkg::DW;

  logic [brf_pkg::CW-1:0]          wcnt_q, wcnt_d, rcnt_q, rcnt_d;
  logic [brf_pkg::CW-1:0]          fill, room, cnt_ext;
  logic [brf_pkg::CNTW-1:0]        moved;
  brf_pkg::status_e                status;
  logic                            fire, is_put, is_rd;
  logic [brf_pkg::BANKS-1:0][7:0]  put_bytes;
  logic [7:0]                      bank_rd [brf_pkg::BANKS];

  // execute -> data stage
  logic                            s2_vld_q, s2_adv;
  logic                            s2_rd_q;
  logic [brf_pkg::CNTW-1:0]        s2_moved_q;
  brf_pkg::status_e                s2_status_q;
  logic [brf_pkg::BW-1:0]          s2_r0_q;

  // result register
  logic                            out_vld_q;
  logic [brf_pkg::CNTW-1:0]        out_moved_q;
  logic [brf_pkg::DW-1:0]          out_data_q, out_data_d;
  brf_pkg::status_e                out_status_q;

  assign s2_adv      = s2_vld_q && (!out_vld_q || m_axis_tready);
  assign req_ready_o = !s2_vld_q || s2_adv;
  assign fire        = req_valid_i && req_ready_o;
  assign put_bytes   = req_i.data;

  always_comb begin
    fill    = wcnt_q - rcnt_q;
    room    = brf_pkg::CW'(brf_pkg::CAPACITY) - fill;
    cnt_ext = brf_pkg::CW'(req_i.cnt);
    moved   = '0;
    status  = brf_pkg::ST_OK;
    is_put  = 1'b0;
    is_rd   = 1'b0;
    unique case (req_i.func)
      brf_pkg::FN_PUT: begin
        is_put = 1'b1;
        if (fill == brf_pkg::CW'(brf_pkg::CAPACITY)) begin
          status = brf_pkg::ST_FULL;
        end else if (cnt_ext <= room) begin
          moved = req_i.cnt;
        end else begin
          moved = room[brf_pkg::CNTW-1:0];
        end
      end
      brf_pkg::FN_GET, brf_pkg::FN_PEEK: begin
        is_rd = 1'b1;
        if (fill == '0) begin
          status = brf_pkg::ST_EMPTY;
        end else if (cnt_ext <= fill) begin
          moved = req_i.cnt;
        end else begin
          moved = fill[brf_pkg::CNTW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wcnt_d = wcnt_q;
    rcnt_d = rcnt_q;
    if (fire && is_put) begin
      wcnt_d = wcnt_q + brf_pkg::CW'(moved);
    end
    if (fire && (req_i.func == brf_pkg::FN_GET)) begin
      rcnt_d = rcnt_q + brf_pkg::CW'(moved);
    end
  end

  for (genvar b = 0; b < brf_pkg::BANKS; b++) begin : g_bank
    logic [7:0]             mem_q [brf_pkg::ROWS];
    logic [7:0]             rd_q;
    logic [brf_pkg::BW-1:0] woff, roff;
    logic [brf_pkg::PW-1:0] wpos, rpos;
    logic [brf_pkg::RW-1:0] wrow, rrow;
    logic                   wen;

    always_comb begin
      woff = brf_pkg::BW'(b) - wcnt_q[brf_pkg::BW-1:0];
      roff = brf_pkg::BW'(b) - rcnt_q[brf_pkg::BW-1:0];
      wpos = wcnt_q[brf_pkg::PW-1:0] + brf_pkg::PW'(woff);
      rpos = rcnt_q[brf_pkg::PW-1:0] + brf_pkg::PW'(roff);
      wrow = wpos[brf_pkg::PW-1:brf_pkg::BW];
      rrow = rpos[brf_pkg::PW-1:brf_pkg::BW];
      wen  = fire && is_put && (brf_pkg::CNTW'(woff) < moved);
    end

    always_ff @(posedge clk_i) begin
      if (wen) begin
        mem_q[wrow] <= put_bytes[woff];
      end
      if (fire) begin
        rd_q <= mem_q[rrow];
      end
    end

    assign bank_rd[b] = rd_q;
  end

  always_comb begin
    logic [brf_pkg::BW-1:0] src;
    for (int i = 0; i < brf_pkg::BANKS; i++) begin
      src = brf_pkg::BW'(i) + s2_r0_q;
      if (s2_rd_q && (brf_pkg::CNTW'(i) < s2_moved_q)) begin
        out_data_d[8*i +: 8] = bank_rd[src];
      end else begin
        out_data_d[8*i +: 8] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q    <= '0;
      rcnt_q    <= '0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      wcnt_q <= wcnt_d;
      rcnt_q <= rcnt_d;
      if (fire) begin
        s2_vld_q <= 1'b1;
      end else if (s2_adv) begin
        s2_vld_q <= 1'b0;
      end
      if (s2_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s2_rd_q     <= is_rd;
      s2_moved_q  <= moved;
      s2_status_q <= status;
      s2_r0_q     <= rcnt_q[brf_pkg::BW-1:0];
    end
    if (s2_adv) begin
      out_moved_q  <= s2_moved_q;
      out_data_q   <= out_data_d;
      out_status_q <= s2_status_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {PADW'(0), out_data_q, out_moved_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// File: hw/rtl/brf_checker.sv
// Port-level checks on the ring FIFO result stream, bound to the top level.
module brf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [brf_pkg::OUT_TDW-1:0]    m_axis_tdata,
  input logic [brf_pkg::STW-1:0]        m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= brf_pkg::CNTW'(brf_pkg::MAX_BYTES))
    else $error("moved count above request limit");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == brf_pkg::ST_EMPTY || m_axis_tuser == brf_pkg::ST_FULL)
      |-> m_axis_tdata == '0)
    else $error("empty or full result carries data");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[brf_pkg::OUT_TDW-1:brf_pkg::CNTW] >> {m_axis_tdata[3:0], 3'b000}) == '0))
    else $error("read bytes beyond moved count not zero");

endmodule

bind byte_ring_fifo_multi_byte brf_checker u_brf_checker (.*);
